FILE: hw/rtl/sca_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sca_pkg: shared types and constants of the crosstalk ratio averager
// Field widths, register indexes, reset values, sequencer states and the
// status bundle of the shared serial divider.
// ----------------------------------------------------------------------------
package sca_pkg;

  // fixed field widths
  localparam int INDEX_W    = 4;
  localparam int VALUE_W    = 8;
  localparam int IMPACT_W   = 24;
  localparam int SCOUNT_W   = 5;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_SENSOR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_COUNT = 1'b1;

  // register reset values
  localparam logic [INDEX_W-1:0]  MAIN_RESET   = 4'd0;
  localparam logic [SCOUNT_W-1:0] SCOUNT_RESET = 5'd16;

  // saturation bound of a reported ratio
  localparam logic [IMPACT_W-1:0] IMPACT_MAX = 24'hFFFFFF;

  // parameter defaults
  localparam int DEF_MAX_SENSORS   = 16;
  localparam int DEF_MAX_RECORDS   = 1024;
  localparam int DEF_FRACTION_BITS = 16;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REC_MAIN,
    ST_REC_CHK,
    ST_REC_SEL,
    ST_REC_START,
    ST_REC_WAIT,
    ST_SET_SEL,
    ST_SET_START,
    ST_SET_WAIT,
    ST_OUT
  } state_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sca_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sca_in_if: input channel of the crosstalk ratio averager
// One beat carries one sensor value with its record and set end marks.
// ----------------------------------------------------------------------------
interface sca_in_if import sca_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] sensor_index;
  logic [VALUE_W-1:0] sensor_value;
  logic               end_of_record;
  logic               end_of_set;

  modport source (
    output valid, sensor_index, sensor_value, end_of_record, end_of_set,
    input  ready
  );

  modport sink (
    input  valid, sensor_index, sensor_value, end_of_record, end_of_set,
    output ready
  );
endinterface
`default_nettype wire

FILE: hw/rtl/sca_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sca_out_if: result channel of the crosstalk ratio averager
// One beat carries the averaged ratio of one sensor.
// ----------------------------------------------------------------------------
interface sca_out_if import sca_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [INDEX_W-1:0]  impacted_sensor;
  logic [IMPACT_W-1:0] impact;
  logic                no_records;
  logic                last;

  modport source (
    output valid, impacted_sensor, impact, no_records, last,
    input  ready
  );

  modport sink (
    input  valid, impacted_sensor, impact, no_records, last,
    output ready
  );
endinterface
`default_nettype wire

FILE: hw/rtl/sensor_crosstalk_ratio_averager.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_crosstalk_ratio_averager: averaged crosstalk ratios per sensor
//
// items carries one sensor peak value per beat. A beat with end_of_record
// closes the record: unless MAX_RECORDS records are held or the main value
// is zero, every used sensor other than the main one adds value / main_value
// (FRACTION_BITS fraction bits) to its running sum. A beat with end_of_set
// emits one beat per used sensor on results, the average sum / record count,
// then clears sums and count (the main sensor reports the unit ratio).
// Each ratio and each average is one pass through the single bit-serial
// divider, one quotient bit per cycle; SUM_W = 8 + FRACTION_BITS +
// log2(MAX_RECORDS) (34 at the defaults) is its dividend width.
// items.ready is high only while no record close or set end is in progress.
// results has an output register: a stalled receiver holds the sequencer
// before the next result, but the last result may wait while new items flow.
// Reset (rst, synchronous) clears the sums, the count, the registers
// (main_sensor 0, sensor_count 16) and the output register; no clearing pass.
// Configuration is written through cfg_we / cfg_idx / cfg_data; the user
// writes it only while idle, and the block itself does not enforce it.
// ----------------------------------------------------------------------------
module sensor_crosstalk_ratio_averager import sca_pkg::*; #(
  parameter int MAX_SENSORS   = DEF_MAX_SENSORS,
  parameter int MAX_RECORDS   = DEF_MAX_RECORDS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  sca_in_if.sink                     items,
  sca_out_if.source                  results
);

  localparam int SENS_W = $clog2(MAX_SENSORS);
  localparam int NCAP   = (MAX_SENSORS < 16) ? MAX_SENSORS : 16;
  localparam int S_W    = $clog2(NCAP);
  localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
  localparam int SUM_W  = VALUE_W + FRACTION_BITS + $clog2(MAX_RECORDS);
  localparam int DEN_W  = (CNT_W > VALUE_W) ? CNT_W : VALUE_W;
  localparam int WIDE_W = (SUM_W > IMPACT_W + 1) ? SUM_W : IMPACT_W + 1;

  state_t state, state_next;

  // configuration registers
  logic [INDEX_W-1:0]  main_sensor;
  logic [SCOUNT_W-1:0] sensor_count;

  // storage
  logic [VALUE_W-1:0]     vals [MAX_SENSORS];
  logic [VALUE_W-1:0]     vals_rd;
  logic [SUM_W-1:0]       sums [MAX_SENSORS];
  logic [SUM_W-1:0]       sum_rd;
  logic [MAX_SENSORS-1:0] sum_vld;
  logic                   sum_rd_vld;
  logic [SUM_W-1:0]       sum_base;
  logic [CNT_W-1:0]       count;
  logic [VALUE_W-1:0]     main_val;

  // sequencing
  logic [S_W-1:0]      s;
  logic [SCOUNT_W-1:0] n_used;
  logic                s_is_main;
  logic                s_last;
  logic                main_ok;
  logic                idx_ok;
  logic [VALUE_W-1:0]  main_val_c;
  logic [SENS_W-1:0]   val_raddr;
  logic                in_beat;

  // control strobes
  logic s_clr, s_inc, count_inc, sum_we, set_clear, res_load, out_load, out_free;
  logic [IMPACT_W-1:0] res_val;
  logic                res_nr;
  logic [IMPACT_W-1:0] res_impact;
  logic                res_no_rec;

  // divider
  logic             div_start;
  logic [SUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  div_stat_t        div_stat;
  logic [SUM_W-1:0] div_quot;

  // saturation
  logic [WIDE_W-1:0]   quot_wide;
  logic [WIDE_W-1:0]   one_wide;
  logic [IMPACT_W-1:0] quot_sat;
  logic [IMPACT_W-1:0] one_sat;

  // output register
  logic                out_valid;
  logic [INDEX_W-1:0]  out_sensor;
  logic [IMPACT_W-1:0] out_impact;
  logic                out_nr;
  logic                out_last;

  sca_serial_div #(
    .NUM_W (SUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  // sensors in use, clamped to the store
  always_comb begin
    if (sensor_count == '0) begin
      n_used = SCOUNT_W'(1);
    end else if (sensor_count > SCOUNT_W'(NCAP)) begin
      n_used = SCOUNT_W'(NCAP);
    end else begin
      n_used = sensor_count;
    end
  end

  assign s_is_main  = (INDEX_W'(s) == main_sensor);
  assign s_last     = ((SCOUNT_W'(s) + SCOUNT_W'(1)) == n_used);
  assign main_ok    = (32'(main_sensor) < MAX_SENSORS);
  assign idx_ok     = (32'(items.sensor_index) < MAX_SENSORS);
  assign main_val_c = main_ok ? vals_rd : '0;
  assign in_beat    = items.valid && items.ready;
  assign out_free   = !out_valid || results.ready;

  // saturate a quotient and the unit ratio to the result width
  assign quot_wide = WIDE_W'(div_quot);
  assign one_wide  = WIDE_W'(1) << FRACTION_BITS;
  assign quot_sat  = (quot_wide > WIDE_W'(IMPACT_MAX)) ? IMPACT_MAX
                                                       : quot_wide[IMPACT_W-1:0];
  assign one_sat   = (one_wide > WIDE_W'(IMPACT_MAX)) ? IMPACT_MAX
                                                      : one_wide[IMPACT_W-1:0];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      main_sensor  <= MAIN_RESET;
      sensor_count <= SCOUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MAIN_SENSOR:  main_sensor  <= cfg_data[INDEX_W-1:0];
        REG_SENSOR_COUNT: sensor_count <= cfg_data[SCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer next state and strobes
  always_comb begin
    state_next  = state;
    items.ready = 1'b0;
    s_clr       = 1'b0;
    s_inc       = 1'b0;
    count_inc   = 1'b0;
    sum_we      = 1'b0;
    set_clear   = 1'b0;
    res_load    = 1'b0;
    res_val     = '0;
    res_nr      = 1'b0;
    out_load    = 1'b0;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;
    unique case (state)
      ST_IDLE: begin
        items.ready = 1'b1;
        if (items.valid) begin
          if (items.end_of_set) begin
            s_clr      = 1'b1;
            state_next = ST_SET_SEL;
          end else if (items.end_of_record && count != CNT_W'(MAX_RECORDS)) begin
            count_inc  = 1'b1;
            state_next = ST_REC_MAIN;
          end
        end
      end
      ST_REC_MAIN: begin
        state_next = ST_REC_CHK;
      end
      ST_REC_CHK: begin
        if (main_val_c == '0) begin
          state_next = ST_IDLE;
        end else begin
          s_clr      = 1'b1;
          state_next = ST_REC_SEL;
        end
      end
      ST_REC_SEL: begin
        if (s_is_main) begin
          if (s_last) begin
            state_next = ST_IDLE;
          end else begin
            s_inc = 1'b1;
          end
        end else begin
          state_next = ST_REC_START;
        end
      end
      ST_REC_START: begin
        div_start  = 1'b1;
        div_num    = SUM_W'(vals_rd) << FRACTION_BITS;
        div_den    = DEN_W'(main_val);
        state_next = ST_REC_WAIT;
      end
      ST_REC_WAIT: begin
        if (div_stat.done) begin
          sum_we = 1'b1;
          if (s_last) begin
            state_next = ST_IDLE;
          end else begin
            s_inc      = 1'b1;
            state_next = ST_REC_SEL;
          end
        end
      end
      ST_SET_SEL: begin
        state_next = ST_SET_START;
      end
      ST_SET_START: begin
        if (count == '0) begin
          res_load   = 1'b1;
          res_nr     = 1'b1;
          state_next = ST_OUT;
        end else if (s_is_main) begin
          res_load   = 1'b1;
          res_val    = one_sat;
          state_next = ST_OUT;
        end else begin
          div_start  = 1'b1;
          div_num    = sum_rd_vld ? sum_rd : '0;
          div_den    = DEN_W'(count);
          state_next = ST_SET_WAIT;
        end
      end
      ST_SET_WAIT: begin
        if (div_stat.done) begin
          res_load   = 1'b1;
          res_val    = quot_sat;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (s_last) begin
            set_clear  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            s_inc      = 1'b1;
            state_next = ST_SET_SEL;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // value store: written by in-range non-set-end beats, read at the main sensor or at s
  assign val_raddr = (state == ST_REC_MAIN) ? SENS_W'(main_sensor) : SENS_W'(s);

  always_ff @(posedge clk) begin
    if (in_beat && !items.end_of_set && idx_ok) begin
      vals[SENS_W'(items.sensor_index)] <= items.sensor_value;
    end
    vals_rd <= vals[val_raddr];
  end

  // sum store
  always_ff @(posedge clk) begin
    if (sum_we) begin
      sums[SENS_W'(s)] <= sum_base + div_quot;
    end
    sum_rd <= sums[SENS_W'(s)];
  end

  // sum valid bits, record count, sensor counter
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld <= '0;
      count   <= '0;
      s       <= '0;
    end else begin
      if (set_clear) begin
        sum_vld <= '0;
        count   <= '0;
      end else begin
        if (sum_we) begin
          sum_vld[SENS_W'(s)] <= 1'b1;
        end
        if (count_inc) begin
          count <= count + CNT_W'(1);
        end
      end
      if (s_clr) begin
        s <= '0;
      end else if (s_inc) begin
        s <= s + S_W'(1);
      end
    end
  end

  // working registers of the sequencer
  always_ff @(posedge clk) begin
    sum_rd_vld <= sum_vld[SENS_W'(s)];
    if (state == ST_REC_CHK) begin
      main_val <= main_val_c;
    end
    if (state == ST_REC_START) begin
      sum_base <= sum_rd_vld ? sum_rd : '0;
    end
    if (res_load) begin
      res_impact <= res_val;
      res_no_rec <= res_nr;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sensor <= INDEX_W'(s);
      out_impact <= res_impact;
      out_nr     <= res_no_rec;
      out_last   <= s_last;
    end
  end

  assign results.valid           = out_valid;
  assign results.impacted_sensor = out_sensor;
  assign results.impact          = out_impact;
  assign results.no_records      = out_nr;
  assign results.last            = out_last;

`ifndef SYNTH
  // record count stays within its cap
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_RECORDS))
    else $error("record count above cap");

  // a new result only follows a load from the result state
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(state) == ST_OUT)
    else $error("result shown outside result state");

  // the divider is never restarted mid-division
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // the final result of a set clears the sums and the count
  a_set_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_load && s_last) |=> (count == '0 && sum_vld == '0))
    else $error("set end did not clear the sums");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/sca_serial_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sca_serial_div: bit-serial restoring divider
// Shifts the dividend in one bit per cycle and the quotient out one bit per
// cycle; once all NUM_W bits are through, the quotient is ready and done pulses.
// ----------------------------------------------------------------------------
module sca_serial_div import sca_pkg::*; #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 11
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output div_stat_t             stat,
  output logic      [NUM_W-1:0] quot
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] steps;
  logic [NUM_W-1:0]  work;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  dvs;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;

  // one restoring step: bring down the next dividend bit, try a subtract
  assign trial = {rem, work[NUM_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(NUM_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend / quotient shift register and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      work <= num;
      rem  <= '0;
      dvs  <= den;
    end else if (busy) begin
      work <= {work[NUM_W-2:0], fits};
      rem  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quot      = work;

endmodule
`default_nettype wire
